FILE: hdl/programmable_interval_timer_top_assert.svh
// assertion macros used by the timer top module
`ifndef PROGRAMMABLE_INTERVAL_TIMER_TOP_ASSERT_SVH
`define PROGRAMMABLE_INTERVAL_TIMER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PIT_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define PIT_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/pit_pkg.sv
// shared types and constants of the interval timer
package pit_pkg;

  localparam int NumTimersDef = 3;

  // request kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_GATE  = 2'd3;

  localparam logic [1:0] PORT_CTRL = 2'd3;
  localparam logic [1:0] SEL_RB    = 2'd3;

  // counter flag bit positions
  localparam int FL_THIT     = 0;
  localparam int FL_ENABLED  = 1;
  localparam int FL_GATE     = 2;
  localparam int FL_DISABLED = 3;
  localparam int FL_INITIAL  = 4;
  localparam int FL_NEWCOUNT = 5;
  localparam int FL_LATCHED  = 6;
  localparam int FL_REREAD   = 7;
  localparam int FL_STATUS   = 8;
  localparam int FL_OUT      = 9;

  // operation on one counter
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CTRL,
    OP_RB,
    OP_WR,
    OP_RD,
    OP_TICK,
    OP_GATE
  } pit_op_e;

  typedef struct packed {
    pit_op_e    op;
    logic [7:0] data;
    logic       gate;
    logic       rb_cnt;
    logic       rb_st;
  } pit_cmd_t;

endpackage

FILE: hdl/pit_req_if.sv
// request and result channel interfaces of the interval timer
interface pit_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] port;
  logic [7:0] write_data;
  logic [1:0] counter_sel;
  logic       gate_level;

  modport source (output valid, kind, port, write_data, counter_sel, gate_level,
                  input ready);
  modport sink   (input valid, kind, port, write_data, counter_sel, gate_level,
                  output ready);
endinterface

interface pit_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       out_zero;
  logic       out_one;
  logic       out_two;

  modport source (output valid, read_data, out_zero, out_one, out_two, input ready);
  modport sink   (input valid, read_data, out_zero, out_one, out_two, output ready);
endinterface

FILE: hdl/pit_counter.sv
// one timer counter: reload, count, latches, mode and flags
module pit_counter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pit_pkg::pit_cmd_t cmd_i,
  output logic [7:0]        rd_data_o,
  output logic              out_o
);
  import pit_pkg::*;

  typedef struct packed {
    logic [15:0] reload;
    logic [16:0] count;
    logic [16:0] latched;
    logic [2:0]  mode;
    logic [1:0]  rd_order;
    logic [1:0]  wr_order;
    logic [7:0]  control;
    logic [7:0]  status;
    logic [9:0]  flags;
  } cnt_t;

  // state after reset: full reload, terminal-hit set
  localparam cnt_t CntRst = '{reload: 16'hffff, flags: 10'(1 << FL_THIT), default: '0};

  cnt_t st_q, st_d;

  function automatic logic [16:0] full_reload(cnt_t s);
    return (s.reload == 16'h0) ? 17'h10000 : {1'b0, s.reload};
  endfunction

  function automatic logic [16:0] live_count(cnt_t s);
    return (s.mode == 3'd2) ? s.count + 17'd1 : s.count;
  endfunction

  function automatic cnt_t latch_count(cnt_t s);
    cnt_t r;
    r = s;
    r.latched = live_count(s);
    r.flags[FL_REREAD] = 1'b0;
    r.rd_order = 2'd3;
    r.flags[FL_LATCHED] = 1'b1;
    return r;
  endfunction

  function automatic cnt_t load_counter(cnt_t s);
    cnt_t        r;
    logic [16:0] l;
    logic        init;
    logic        g;
    r = s;
    l = full_reload(s);
    init = s.flags[FL_INITIAL];
    g = s.flags[FL_GATE];
    r.flags[FL_NEWCOUNT] = 1'b0;
    r.flags[FL_DISABLED] = 1'b0;
    unique case (s.mode)
      3'd0: begin
        r.count = l;
        r.flags[FL_OUT] = 1'b0;
        r.flags[FL_THIT] = 1'b0;
        r.flags[FL_ENABLED] = g;
      end
      3'd2: begin
        if (init) begin
          r.count = l - 17'd1;
          r.flags[FL_OUT] = 1'b1;
          r.flags[FL_THIT] = 1'b0;
        end
        r.flags[FL_ENABLED] = g;
      end
      3'd3: begin
        if (init) begin
          r.count = l;
          r.flags[FL_NEWCOUNT] = l[0];
          r.flags[FL_OUT] = 1'b1;
          r.flags[FL_THIT] = 1'b0;
        end
        r.flags[FL_ENABLED] = g;
      end
      3'd4: begin
        if (!s.flags[FL_THIT] && !init) begin
          r.flags[FL_NEWCOUNT] = 1'b1;
        end else begin
          r.count = l;
          r.flags[FL_OUT] = 1'b0;
          r.flags[FL_THIT] = 1'b0;
        end
        r.flags[FL_ENABLED] = g;
      end
      default: begin
        r.flags[FL_ENABLED] = 1'b1;
      end
    endcase
    r.flags[FL_INITIAL] = 1'b0;
    return r;
  endfunction

  function automatic cnt_t terminal(cnt_t s);
    cnt_t        r;
    logic [16:0] l;
    r = s;
    l = full_reload(s);
    if (s.flags[FL_DISABLED]) begin
      r.count = s.count + 17'h0ffff;
    end else begin
      unique case (s.mode)
        3'd0, 3'd1, 3'd5: begin
          r.flags[FL_OUT] = 1'b1;
          r.flags[FL_THIT] = 1'b1;
          r.count = s.count + 17'h0ffff;
        end
        3'd2: begin
          r.count = s.count + l;
          r.flags[FL_OUT] = 1'b1;
        end
        3'd3: begin
          r.flags[FL_OUT] = !s.flags[FL_OUT];
          r.count = s.count + l;
          r.flags[FL_NEWCOUNT] = l[0];
        end
        default: begin
          if (!s.flags[FL_THIT]) r.flags[FL_OUT] = 1'b1;
          if (s.flags[FL_NEWCOUNT]) begin
            r.flags[FL_NEWCOUNT] = 1'b0;
            r.count = s.count + l;
          end else begin
            r.flags[FL_THIT] = 1'b1;
            r.count = s.count + 17'h0ffff;
          end
        end
      endcase
    end
    return r;
  endfunction

  // next state and read byte for this request
  always_comb begin
    cnt_t        s;
    logic [16:0] l;
    logic [16:0] dec;
    logic        rise;
    logic [2:0]  m;
    s = st_q;
    rd_data_o = 8'hff;
    l = full_reload(st_q);
    dec = 17'd1;
    rise = 1'b0;
    m = 3'd0;
    unique case (cmd_i.op)
      OP_CTRL: begin
        if (cmd_i.data[5:4] == 2'd0) begin
          s = latch_count(s);
        end else begin
          m = cmd_i.data[3:1];
          if (m > 3'd5) m = {1'b0, m[1:0]};
          s.control = cmd_i.data;
          s.rd_order = cmd_i.data[5:4];
          s.wr_order = cmd_i.data[5:4];
          s.mode = m;
          s.flags[FL_REREAD] = 1'b1;
          s.flags[FL_INITIAL] = 1'b1;
          s.flags[FL_OUT] = (m != 3'd0);
          s.flags[FL_DISABLED] = 1'b1;
        end
        s.flags[FL_THIT] = 1'b0;
      end
      OP_RB: begin
        if (cmd_i.rb_cnt) s = latch_count(s);
        if (cmd_i.rb_st) begin
          s.status = (s.control & 8'h3f) | (s.flags[FL_OUT] ? 8'h80 : 8'h00);
          s.flags[FL_STATUS] = 1'b1;
        end
      end
      OP_WR: begin
        unique case (s.wr_order)
          2'd1: begin
            s.reload = {8'h00, cmd_i.data};
            s = load_counter(s);
          end
          2'd2: begin
            s.reload = {cmd_i.data, 8'h00};
            s = load_counter(s);
          end
          2'd0: begin
            s.reload = {cmd_i.data, s.reload[7:0]};
            s = load_counter(s);
            s.wr_order = 2'd3;
          end
          default: begin
            s.reload = {s.reload[15:8], cmd_i.data};
            s.wr_order = 2'd0;
          end
        endcase
      end
      OP_RD: begin
        if (s.flags[FL_STATUS]) begin
          s.flags[FL_STATUS] = 1'b0;
          rd_data_o = s.status;
        end else begin
          if (s.flags[FL_REREAD] && !s.flags[FL_LATCHED]) begin
            s.flags[FL_REREAD] = 1'b0;
            s.latched = live_count(s);
          end
          unique case (s.rd_order)
            2'd0: begin
              rd_data_o = s.latched[15:8];
              s.rd_order = 2'd3;
              s.flags[FL_LATCHED] = 1'b0;
              s.flags[FL_REREAD] = 1'b1;
            end
            2'd1: begin
              rd_data_o = s.latched[7:0];
              s.flags[FL_LATCHED] = 1'b0;
              s.flags[FL_REREAD] = 1'b1;
            end
            2'd2: begin
              rd_data_o = s.latched[15:8];
              s.flags[FL_LATCHED] = 1'b0;
              s.flags[FL_REREAD] = 1'b1;
            end
            default: begin
              rd_data_o = s.latched[7:0];
              s.rd_order = 2'd0;
            end
          endcase
        end
      end
      OP_TICK: begin
        if (!s.flags[FL_THIT] && s.flags[FL_ENABLED]) begin
          if (s.mode == 3'd3 && s.flags[FL_NEWCOUNT]) begin
            dec = s.flags[FL_OUT] ? 17'd1 : 17'd3;
            s.flags[FL_NEWCOUNT] = 1'b0;
          end else begin
            dec = (s.mode == 3'd3) ? 17'd2 : 17'd1;
          end
          s.count = s.count - dec;
          if (s.count == 17'd0) s = terminal(s);
        end
      end
      OP_GATE: begin
        rise = cmd_i.gate && !s.flags[FL_GATE];
        if (!s.flags[FL_DISABLED]) begin
          unique case (s.mode)
            3'd0, 3'd4: begin
              s.flags[FL_ENABLED] = cmd_i.gate;
            end
            3'd1, 3'd5: begin
              if (rise) begin
                s.count = l;
                s.flags[FL_OUT] = 1'b0;
                s.flags[FL_THIT] = 1'b0;
                s.flags[FL_ENABLED] = 1'b1;
              end
            end
            3'd2: begin
              if (rise) begin
                s.count = l - 17'd1;
                s.flags[FL_OUT] = 1'b1;
                s.flags[FL_THIT] = 1'b0;
              end
              s.flags[FL_ENABLED] = cmd_i.gate;
            end
            default: begin
              if (rise) begin
                s.count = l;
                s.flags[FL_NEWCOUNT] = l[0];
                s.flags[FL_OUT] = 1'b1;
                s.flags[FL_THIT] = 1'b0;
              end
              s.flags[FL_ENABLED] = cmd_i.gate;
            end
          endcase
        end
        s.flags[FL_GATE] = cmd_i.gate;
      end
      default: begin
      end
    endcase
    st_d = s;
  end

  assign out_o = st_d.flags[FL_OUT];

  // counter state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CntRst;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

FILE: hdl/programmable_interval_timer_top.sv
// Three-counter interval timer, 8253/8254 style. One request is taken every clock cycle that
// ready is high, and its result appears in the result register on the next cycle; the request
// is decoded and all counter state is updated by logic between the request handshake and that
// register. Ready falls only while a result sits in the register and is not being taken.
// Counters at or above NUM_TIMERS are absent: their requests are ignored, reads give 0xff.
module programmable_interval_timer_top #(
  parameter int NUM_TIMERS = pit_pkg::NumTimersDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_data_i,
  pit_req_if.sink   req_i,
  pit_rsp_if.source rsp_o
);
  import pit_pkg::*;
  `include "programmable_interval_timer_top_assert.svh"

  logic       is_8254_q;
  logic [7:0] last_ctl_q, last_ctl_d;
  logic       rsp_valid_q;
  logic [7:0] rd_q, rd_d;
  logic [2:0] outs_q;
  logic       accept;

  pit_cmd_t   cmd [4];
  logic [7:0] cnt_rd [4];
  logic       cnt_out [4];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept = req_i.valid && req_i.ready;

  // per-counter operation decode
  always_comb begin
    logic [1:0] t;
    t = req_i.write_data[7:6];
    for (int i = 0; i < 4; i++) begin
      cmd[i] = '0;
      cmd[i].op = OP_NONE;
      cmd[i].data = req_i.write_data;
      cmd[i].gate = req_i.gate_level;
      cmd[i].rb_cnt = !req_i.write_data[5];
      cmd[i].rb_st = !req_i.write_data[4];
    end
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        unique case (req_i.kind)
          KIND_WRITE: begin
            if (req_i.port == PORT_CTRL) begin
              if (t == SEL_RB) begin
                if (is_8254_q && req_i.write_data[i + 1]) cmd[i].op = OP_RB;
              end else if (t == 2'(i)) begin
                cmd[i].op = OP_CTRL;
              end
            end else if (req_i.port == 2'(i)) begin
              cmd[i].op = OP_WR;
            end
          end
          KIND_READ: if (req_i.port == 2'(i)) cmd[i].op = OP_RD;
          KIND_TICK: if (req_i.counter_sel == 2'(i)) cmd[i].op = OP_TICK;
          default:   if (req_i.counter_sel == 2'(i)) cmd[i].op = OP_GATE;
        endcase
      end
    end
  end

  // counters that exist, idle values for the rest
  for (genvar g = 0; g < 4; g++) begin : g_cnt
    if (g < NUM_TIMERS) begin : g_on
      pit_counter u_cnt (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cmd_i    (cmd[g]),
        .rd_data_o(cnt_rd[g]),
        .out_o    (cnt_out[g])
      );
    end else begin : g_off
      assign cnt_rd[g] = 8'hff;
      assign cnt_out[g] = 1'b0;
    end
  end

  // last control word and read byte
  always_comb begin
    last_ctl_d = last_ctl_q;
    if (req_i.kind == KIND_WRITE && req_i.port == PORT_CTRL
        && req_i.write_data[7:6] != SEL_RB
        && int'(req_i.write_data[7:6]) < NUM_TIMERS) begin
      last_ctl_d = (req_i.write_data[5:4] == 2'd0) ? (req_i.write_data | 8'h30)
                                                    : req_i.write_data;
    end
    rd_d = 8'hff;
    if (req_i.kind == KIND_READ) begin
      if (req_i.port == PORT_CTRL) rd_d = is_8254_q ? last_ctl_q : 8'h00;
      else rd_d = cnt_rd[req_i.port];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_8254_q <= 1'b1;
      last_ctl_q <= 8'h00;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) is_8254_q <= cfg_data_i;
      if (accept) last_ctl_q <= last_ctl_d;
      if (accept) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= rd_d;
      outs_q <= {cnt_out[2], cnt_out[1], cnt_out[0]};
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.read_data = rd_q;
  assign rsp_o.out_zero = outs_q[0];
  assign rsp_o.out_one = outs_q[1];
  assign rsp_o.out_two = outs_q[2];

  `PIT_ASSERT_NOW(a_ready_when_empty, !rsp_valid_q, req_i.ready, "not ready with empty result register")
  `PIT_ASSERT_NEXT(a_result_follows, accept, rsp_valid_q, "accepted request gave no result")
  `PIT_ASSERT_NEXT(a_nonread_ff, accept && req_i.kind != KIND_READ, rd_q == 8'hff, "read byte not 0xff for a non-read request")

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the three-counter interval timer
module tb_top;
  import pit_pkg::*;

  localparam int NTMR = 3;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] port;
    logic [7:0] wdata;
    logic [1:0] sel;
    logic       gate;
  } timer_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       o0;
    logic       o1;
    logic       o2;
  } timer_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  pit_req_if req_if ();
  pit_rsp_if rsp_if ();

  programmable_interval_timer_top #(.NUM_TIMERS(NTMR)) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if.sink),
    .rsp_o     (rsp_if.source)
  );

  // shadow copy of the timer state
  logic        m_is8254;
  logic [15:0] m_reload [NTMR];
  logic [16:0] m_count  [NTMR];
  logic [16:0] m_latch  [NTMR];
  logic [2:0]  m_mode   [NTMR];
  logic [1:0]  m_rord   [NTMR];
  logic [1:0]  m_word   [NTMR];
  logic [7:0]  m_ctrl   [NTMR];
  logic [7:0]  m_status [NTMR];
  logic [9:0]  m_flags  [NTMR];
  logic [7:0]  m_lastctl;

  timer_req_t pending_reqs[$];
  timer_rsp_t expected_rsps[$];
  int  errors;
  int  n_accepted;
  int  n_checked;
  int  idle_cycles;
  logic stress_on;
  logic stim_done;

  function automatic logic [16:0] full_reload(int t);
    return (m_reload[t] == 16'd0) ? 17'h10000 : {1'b0, m_reload[t]};
  endfunction

  function automatic logic [16:0] live_count(int t);
    return (m_mode[t] == 3'd2) ? m_count[t] + 17'd1 : m_count[t];
  endfunction

  function automatic void latch_count(int t);
    m_latch[t] = live_count(t);
    m_flags[t][FL_REREAD] = 1'b0;
    m_rord[t] = 2'd3;
    m_flags[t][FL_LATCHED] = 1'b1;
  endfunction

  function automatic void load_counter(int t);
    logic [16:0] l;
    logic ini, g;
    l = full_reload(t);
    ini = m_flags[t][FL_INITIAL];
    g = m_flags[t][FL_GATE];
    m_flags[t][FL_NEWCOUNT] = 1'b0;
    m_flags[t][FL_DISABLED] = 1'b0;
    case (m_mode[t])
      3'd0: begin
        m_count[t] = l;
        m_flags[t][FL_OUT] = 1'b0;
        m_flags[t][FL_THIT] = 1'b0;
        m_flags[t][FL_ENABLED] = g;
      end
      3'd2: begin
        if (ini) begin
          m_count[t] = l - 17'd1;
          m_flags[t][FL_OUT] = 1'b1;
          m_flags[t][FL_THIT] = 1'b0;
        end
        m_flags[t][FL_ENABLED] = g;
      end
      3'd3: begin
        if (ini) begin
          m_count[t] = l;
          m_flags[t][FL_NEWCOUNT] = l[0];
          m_flags[t][FL_OUT] = 1'b1;
          m_flags[t][FL_THIT] = 1'b0;
        end
        m_flags[t][FL_ENABLED] = g;
      end
      3'd4: begin
        if (!m_flags[t][FL_THIT] && !ini) begin
          m_flags[t][FL_NEWCOUNT] = 1'b1;
        end else begin
          m_count[t] = l;
          m_flags[t][FL_OUT] = 1'b0;
          m_flags[t][FL_THIT] = 1'b0;
        end
        m_flags[t][FL_ENABLED] = g;
      end
      default: m_flags[t][FL_ENABLED] = 1'b1;
    endcase
    m_flags[t][FL_INITIAL] = 1'b0;
  endfunction

  // terminal count handling per mode
  function automatic void terminal_count(int t);
    logic [16:0] l;
    l = full_reload(t);
    if (m_flags[t][FL_DISABLED]) begin
      m_count[t] = m_count[t] + 17'hffff;
      return;
    end
    case (m_mode[t])
      3'd0, 3'd1, 3'd5: begin
        m_flags[t][FL_OUT] = 1'b1;
        m_flags[t][FL_THIT] = 1'b1;
        m_count[t] = m_count[t] + 17'hffff;
      end
      3'd2: begin
        m_count[t] = m_count[t] + l;
        m_flags[t][FL_OUT] = 1'b1;
      end
      3'd3: begin
        m_flags[t][FL_OUT] = !m_flags[t][FL_OUT];
        m_count[t] = m_count[t] + l;
        m_flags[t][FL_NEWCOUNT] = l[0];
      end
      default: begin
        if (!m_flags[t][FL_THIT]) m_flags[t][FL_OUT] = 1'b1;
        if (m_flags[t][FL_NEWCOUNT]) begin
          m_flags[t][FL_NEWCOUNT] = 1'b0;
          m_count[t] = m_count[t] + l;
        end else begin
          m_flags[t][FL_THIT] = 1'b1;
          m_count[t] = m_count[t] + 17'hffff;
        end
      end
    endcase
  endfunction

  function automatic void count_tick(int t);
    logic [16:0] dec;
    if (m_flags[t][FL_THIT] || !m_flags[t][FL_ENABLED]) return;
    if (m_mode[t] == 3'd3 && m_flags[t][FL_NEWCOUNT]) begin
      dec = m_flags[t][FL_OUT] ? 17'd1 : 17'd3;
      m_flags[t][FL_NEWCOUNT] = 1'b0;
    end else begin
      dec = (m_mode[t] == 3'd3) ? 17'd2 : 17'd1;
    end
    m_count[t] = m_count[t] - dec;
    if (m_count[t] == 17'd0) terminal_count(t);
  endfunction

  function automatic void change_gate(int t, logic g);
    logic [16:0] l;
    logic rise;
    l = full_reload(t);
    rise = g && !m_flags[t][FL_GATE];
    if (!m_flags[t][FL_DISABLED]) begin
      case (m_mode[t])
        3'd0, 3'd4: m_flags[t][FL_ENABLED] = g;
        3'd1, 3'd5: begin
          if (rise) begin
            m_count[t] = l;
            m_flags[t][FL_OUT] = 1'b0;
            m_flags[t][FL_THIT] = 1'b0;
            m_flags[t][FL_ENABLED] = 1'b1;
          end
        end
        3'd2: begin
          if (rise) begin
            m_count[t] = l - 17'd1;
            m_flags[t][FL_OUT] = 1'b1;
            m_flags[t][FL_THIT] = 1'b0;
          end
          m_flags[t][FL_ENABLED] = g;
        end
        default: begin
          if (rise) begin
            m_count[t] = l;
            m_flags[t][FL_NEWCOUNT] = l[0];
            m_flags[t][FL_OUT] = 1'b1;
            m_flags[t][FL_THIT] = 1'b0;
          end
          m_flags[t][FL_ENABLED] = g;
        end
      endcase
    end
    m_flags[t][FL_GATE] = g;
  endfunction

  // control word: mode set, counter latch or read-back
  function automatic void control_write(logic [7:0] v);
    int t;
    logic [2:0] m;
    t = v[7:6];
    if (v[7:6] == SEL_RB) begin
      if (!m_is8254) return;
      for (int i = 0; i < NTMR; i++) begin
        if (v[i+1]) begin
          if (!v[5]) latch_count(i);
          if (!v[4]) begin
            m_status[i] = (m_ctrl[i] & 8'h3f) | (m_flags[i][FL_OUT] ? 8'h80 : 8'h00);
            m_flags[i][FL_STATUS] = 1'b1;
          end
        end
      end
      return;
    end
    if (t >= NTMR) return;
    m_lastctl = v;
    if (v[5:4] == 2'b00) begin
      latch_count(t);
      m_lastctl = m_lastctl | 8'h30;
    end else begin
      m = v[3:1];
      if (m > 3'd5) m = m & 3'd3;
      m_ctrl[t] = v;
      m_rord[t] = v[5:4];
      m_word[t] = v[5:4];
      m_mode[t] = m;
      m_flags[t][FL_REREAD] = 1'b1;
      m_flags[t][FL_INITIAL] = 1'b1;
      m_flags[t][FL_OUT] = (m != 3'd0);
      m_flags[t][FL_DISABLED] = 1'b1;
    end
    m_flags[t][FL_THIT] = 1'b0;
  endfunction

  function automatic void counter_write(int t, logic [7:0] v);
    case (m_word[t])
      2'd1: begin
        m_reload[t] = {8'h00, v};
        load_counter(t);
      end
      2'd2: begin
        m_reload[t] = {v, 8'h00};
        load_counter(t);
      end
      2'd0: begin
        m_reload[t] = {v, m_reload[t][7:0]};
        load_counter(t);
        m_word[t] = 2'd3;
      end
      default: begin
        m_reload[t] = {m_reload[t][15:8], v};
        m_word[t] = 2'd0;
      end
    endcase
  endfunction

  function automatic logic [7:0] counter_read(int t);
    logic [7:0] r;
    if (m_flags[t][FL_STATUS]) begin
      m_flags[t][FL_STATUS] = 1'b0;
      return m_status[t];
    end
    if (m_flags[t][FL_REREAD] && !m_flags[t][FL_LATCHED]) begin
      m_flags[t][FL_REREAD] = 1'b0;
      m_latch[t] = live_count(t);
    end
    case (m_rord[t])
      2'd0: begin
        r = m_latch[t][15:8];
        m_rord[t] = 2'd3;
        m_flags[t][FL_LATCHED] = 1'b0;
        m_flags[t][FL_REREAD] = 1'b1;
      end
      2'd1: begin
        r = m_latch[t][7:0];
        m_flags[t][FL_LATCHED] = 1'b0;
        m_flags[t][FL_REREAD] = 1'b1;
      end
      2'd2: begin
        r = m_latch[t][15:8];
        m_flags[t][FL_LATCHED] = 1'b0;
        m_flags[t][FL_REREAD] = 1'b1;
      end
      default: begin
        r = m_latch[t][7:0];
        m_rord[t] = 2'd0;
      end
    endcase
    return r;
  endfunction

  task automatic timer_reset_state();
    m_is8254 = 1'b1;
    for (int i = 0; i < NTMR; i++) begin
      m_reload[i] = 16'hffff;
      m_count[i] = '0;
      m_latch[i] = '0;
      m_mode[i] = '0;
      m_rord[i] = '0;
      m_word[i] = '0;
      m_ctrl[i] = '0;
      m_status[i] = '0;
      m_flags[i] = 10'd1 << FL_THIT;
    end
    m_lastctl = '0;
  endtask

  // advance the shadow state by one request and return the result it gives
  function automatic timer_rsp_t timer_step(timer_req_t q);
    timer_rsp_t r;
    r.rdata = 8'hff;
    case (q.kind)
      KIND_WRITE: begin
        if (q.port == PORT_CTRL) control_write(q.wdata);
        else if (q.port < NTMR) counter_write(q.port, q.wdata);
      end
      KIND_READ: begin
        if (q.port == PORT_CTRL) r.rdata = m_is8254 ? m_lastctl : 8'h00;
        else if (q.port < NTMR) r.rdata = counter_read(q.port);
      end
      KIND_TICK: if (q.sel < NTMR) count_tick(q.sel);
      default:   if (q.sel < NTMR) change_gate(q.sel, q.gate);
    endcase
    r.o0 = m_flags[0][FL_OUT];
    r.o1 = m_flags[1][FL_OUT];
    r.o2 = m_flags[2][FL_OUT];
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      timer_req_t nxt;
      if (req_if.valid && req_if.ready) begin
        void'(pending_reqs.pop_front());
        expected_rsps.push_back(timer_step({req_if.kind, req_if.port,
            req_if.write_data, req_if.counter_sel, req_if.gate_level}));
        n_accepted++;
      end
      // a waiting request holds until taken
      if (req_if.valid && !req_if.ready) begin
        req_if.valid <= 1'b1;
      end else if (pending_reqs.size() > 0 && (!stress_on || $urandom_range(99) >= 22)) begin
        nxt = pending_reqs[0];
        req_if.valid       <= 1'b1;
        req_if.kind        <= nxt.kind;
        req_if.port        <= nxt.port;
        req_if.write_data  <= nxt.wdata;
        req_if.counter_sel <= nxt.sel;
        req_if.gate_level  <= nxt.gate;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        timer_rsp_t e;
        if (expected_rsps.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          n_checked++;
          if (rsp_if.read_data !== e.rdata) begin
            $error("read_data exp %0h got %0h", e.rdata, rsp_if.read_data);
            errors++;
          end
          if (rsp_if.out_zero !== e.o0) begin
            $error("out_zero exp %0b got %0b", e.o0, rsp_if.out_zero);
            errors++;
          end
          if (rsp_if.out_one !== e.o1) begin
            $error("out_one exp %0b got %0b", e.o1, rsp_if.out_one);
            errors++;
          end
          if (rsp_if.out_two !== e.o2) begin
            $error("out_two exp %0b got %0b", e.o2, rsp_if.out_two);
            errors++;
          end
        end
      end
      rsp_if.ready <= !stress_on || $urandom_range(99) >= 22;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic timer_req_t mk(logic [1:0] k, logic [1:0] p, logic [7:0] d,
                                    logic [1:0] s, logic g);
    timer_req_t q;
    q.kind = k;
    q.port = p;
    q.wdata = d;
    q.sel = s;
    q.gate = g;
    return q;
  endfunction

  // a well-formed programming sequence with random content
  task automatic add_program_seq();
    logic [1:0] t;
    logic [1:0] rw;
    logic [7:0] cw;
    t = $urandom_range(2);
    rw = $urandom_range(3, 1);
    cw = {t, rw, 3'($urandom), 1'($urandom)};
    pending_reqs.push_back(mk(KIND_GATE, 2'($urandom), 8'($urandom), t, 1'b1));
    pending_reqs.push_back(mk(KIND_WRITE, PORT_CTRL, cw, 2'($urandom), 1'($urandom)));
    if (rw != 2'd2)
      pending_reqs.push_back(mk(KIND_WRITE, t, 8'($urandom_range(6)), 2'($urandom), 1'b0));
    if (rw != 2'd1)
      pending_reqs.push_back(mk(KIND_WRITE, t, ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0,
                                2'($urandom), 1'b0));
    repeat ($urandom_range(30, 4))
      pending_reqs.push_back(mk(KIND_TICK, 2'($urandom), 8'($urandom),
                                ($urandom_range(3) == 0) ? 2'($urandom) : t, 1'($urandom)));
  endtask

  task automatic add_random_item();
    int c;
    c = $urandom_range(99);
    if (c < 45)
      pending_reqs.push_back(mk(KIND_TICK, 2'($urandom), 8'($urandom), 2'($urandom),
                                1'($urandom)));
    else if (c < 60)
      pending_reqs.push_back(mk(KIND_READ, 2'($urandom), 8'($urandom), 2'($urandom),
                                1'($urandom)));
    else if (c < 72)
      pending_reqs.push_back(mk(KIND_GATE, 2'($urandom), 8'($urandom), 2'($urandom),
                                1'($urandom)));
    else
      pending_reqs.push_back(mk(KIND_WRITE, 2'($urandom), 8'($urandom), 2'($urandom),
                                1'($urandom)));
  endtask

  task automatic drain_and_config(logic v);
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    m_is8254 = v;
  endtask

  initial begin
    errors = 0;
    n_accepted = 0;
    n_checked = 0;
    idle_cycles = 0;
    stress_on = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = 1'b1;
    req_if.valid = 1'b0;
    req_if.kind = '0;
    req_if.port = '0;
    req_if.write_data = '0;
    req_if.counter_sel = '0;
    req_if.gate_level = 1'b0;
    rsp_if.ready = 1'b0;
    timer_reset_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register explicitly set to its reset value first
    drain_and_config(1'b1);

    // directed: write order after reset, latch, read-back, tiny reload wrap
    pending_reqs.push_back(mk(KIND_WRITE, 2'd0, 8'h12, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_READ, PORT_CTRL, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_WRITE, PORT_CTRL, 8'h34, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_GATE, 2'd0, 8'h00, 2'd0, 1'b1));
    pending_reqs.push_back(mk(KIND_WRITE, 2'd0, 8'h01, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_WRITE, 2'd0, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_TICK, 2'd0, 8'hff, 2'd0, 1'b1));
    pending_reqs.push_back(mk(KIND_TICK, 2'd0, 8'hff, 2'd0, 1'b1));
    pending_reqs.push_back(mk(KIND_WRITE, PORT_CTRL, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_WRITE, PORT_CTRL, 8'h96, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_GATE, 2'd0, 8'h00, 2'd2, 1'b1));
    pending_reqs.push_back(mk(KIND_WRITE, 2'd2, 8'hff, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_TICK, 2'd0, 8'h00, 2'd2, 1'b0));
    pending_reqs.push_back(mk(KIND_WRITE, PORT_CTRL, 8'hce, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_READ, 2'd2, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_READ, 2'd2, 8'h00, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_TICK, 2'd0, 8'h00, SEL_RB, 1'b0));
    pending_reqs.push_back(mk(KIND_GATE, 2'd0, 8'h00, SEL_RB, 1'b1));
    pending_reqs.push_back(mk(KIND_WRITE, PORT_CTRL, 8'h7a, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_GATE, 2'd0, 8'h00, 2'd1, 1'b0));
    pending_reqs.push_back(mk(KIND_GATE, 2'd0, 8'h00, 2'd1, 1'b1));
    drain_and_config(1'b0);
    pending_reqs.push_back(mk(KIND_WRITE, PORT_CTRL, 8'hc2, 2'd0, 1'b0));
    pending_reqs.push_back(mk(KIND_READ, PORT_CTRL, 8'h00, 2'd0, 1'b0));

    // random phases alternating the register, no idling in the first one
    for (int ph = 0; ph < 6; ph++) begin
      int target;
      target = n_accepted + pending_reqs.size() + 170;
      stress_on = (ph != 0);
      while (n_accepted + pending_reqs.size() < target) begin
        if ($urandom_range(99) < 60) add_program_seq();
        else add_random_item();
      end
      drain_and_config((ph % 2) == 0 ? 1'b1 : 1'b0);
    end
    stim_done = 1'b1;
    repeat (10) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked, both 8253 and 8254 behavior",
             n_accepted, n_checked);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
